/* src/bcpwm_pkg.sv */
`timescale 1ns / 1ps

package bcpwm_pkg;

   localparam int NUM_PHASES   = 3;
   localparam int PHASE_W      = 2;
   localparam int TOP_W        = 16;
   localparam int CMP_W        = 17;
   localparam int ADV_W        = 15;
   localparam int CHAN_W       = 2;
   localparam int MODE_W       = 3;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;

   localparam logic [MODE_W-1:0] MODE_STEP     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_MANIP    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ENERGIZE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_FREEWHL  = 3'd3;

   localparam logic [CHAN_W-1:0] CH_OFF    = 2'd0;
   localparam logic [CHAN_W-1:0] CH_NONINV = 2'd1;
   localparam logic [CHAN_W-1:0] CH_INV    = 2'd2;

   localparam logic [1:0] CMD_HIGH  = 2'd0;
   localparam logic [1:0] CMD_HALF  = 2'd1;
   localparam logic [1:0] CMD_LOW   = 2'd2;
   localparam logic [1:0] CMD_FLOAT = 2'd3;

   localparam logic [1:0] POL_OFF = 2'b00;
   localparam logic [1:0] POL_TOP = 2'b01;

   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD_TOP = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRAKE_MIN  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADC_ADV    = 2'd2;

   localparam logic [TOP_W-1:0] RESET_TOP       = 16'd2399;
   localparam logic [TOP_W-1:0] RESET_BRAKE_MIN = 16'd0;
   localparam logic [ADV_W-1:0] RESET_ADC_ADV   = 15'd0;
   localparam logic [CMP_W-1:0] RESET_COMPARE   = CMP_W'((RESET_TOP + 1) / 2);
   localparam logic [TOP_W-1:0] RESET_ADC_POINT = TOP_W'(RESET_TOP / 4);

   localparam logic [15:0] FULL_DUTY = 16'd32736;
   localparam logic [13:0] RECIP_5   = 14'd13107;

   typedef struct packed {
      logic [TOP_W-1:0] period_top;
      logic [TOP_W-1:0] brake_min;
      logic [ADV_W-1:0] adc_lead;
   } cfg_type;

   typedef struct packed {
      logic [CMP_W-1:0] converted;
      logic [CMP_W-1:0] high_compare;
   } conv_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic signed [15:0] duty;
      logic [PHASE_W-1:0] positive_phase;
      logic [PHASE_W-1:0] negative_phase;
      logic [PHASE_W-1:0] floating_phase;
      logic [1:0]         cmd_a;
      logic [1:0]         cmd_b;
      logic [1:0]         cmd_c;
      logic signed [1:0]  pol_a;
      logic signed [1:0]  pol_b;
      logic signed [1:0]  pol_c;
   } req_type;

   typedef struct packed {
      logic [CMP_W-1:0]  compare_a;
      logic [CMP_W-1:0]  compare_b;
      logic [CMP_W-1:0]  compare_c;
      logic [CHAN_W-1:0] chan_a;
      logic [CHAN_W-1:0] chan_b;
      logic [CHAN_W-1:0] chan_c;
      logic [TOP_W-1:0]  adc_trigger;
      logic [CMP_W-1:0]  converted;
   } rsp_type;

   function automatic logic [TOP_W-1:0] half_top(input logic [TOP_W-1:0] top);
      logic [TOP_W:0] sum;
      sum = {1'b0, top} + 17'd1;
      return sum[TOP_W:1];
   endfunction

   function automatic logic [CMP_W-1:0] forward_value(input logic [TOP_W-1:0] top,
                                                      input logic [TOP_W-1:0] d);
      logic [TOP_W-1:0] diff;
      diff = top - d;
      return {1'b0, top} - {2'b00, diff[TOP_W-1:1]} + 17'd1;
   endfunction

   function automatic logic [TOP_W-1:0] adc_adjust(input logic [CMP_W-1:0] v,
                                                   input logic [ADV_W-1:0] adv);
      logic [TOP_W-1:0] h;
      h = v[CMP_W-1:1];
      if (h > {1'b0, adv}) begin
         return h - {1'b0, adv};
      end
      return 16'd1;
   endfunction

   function automatic logic [PHASE_W-1:0] phase_sel(input logic [PHASE_W-1:0] raw);
      return (raw == 2'd3) ? 2'd2 : raw;
   endfunction

endpackage

/* src/bcpwm_req_if.sv */
`timescale 1ns / 1ps

interface bcpwm_req_if import bcpwm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic signed [15:0]  duty;
   logic [PHASE_W-1:0]  positive_phase;
   logic [PHASE_W-1:0]  negative_phase;
   logic [PHASE_W-1:0]  floating_phase;
   logic [1:0]          cmd_a;
   logic [1:0]          cmd_b;
   logic [1:0]          cmd_c;
   logic signed [1:0]   pol_a;
   logic signed [1:0]   pol_b;
   logic signed [1:0]   pol_c;

   modport source (
      output valid, mode, duty, positive_phase, negative_phase, floating_phase,
             cmd_a, cmd_b, cmd_c, pol_a, pol_b, pol_c,
      input  ready
   );

   modport sink (
      input  valid, mode, duty, positive_phase, negative_phase, floating_phase,
             cmd_a, cmd_b, cmd_c, pol_a, pol_b, pol_c,
      output ready
   );
endinterface

/* src/bcpwm_rsp_if.sv */
`timescale 1ns / 1ps

interface bcpwm_rsp_if import bcpwm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMP_W-1:0]  compare_a;
   logic [CMP_W-1:0]  compare_b;
   logic [CMP_W-1:0]  compare_c;
   logic [CHAN_W-1:0] chan_a;
   logic [CHAN_W-1:0] chan_b;
   logic [CHAN_W-1:0] chan_c;
   logic [TOP_W-1:0]  adc_trigger;
   logic [CMP_W-1:0]  converted;

   modport source (
      output valid, compare_a, compare_b, compare_c, chan_a, chan_b, chan_c,
             adc_trigger, converted,
      input  ready
   );

   modport sink (
      input  valid, compare_a, compare_b, compare_c, chan_a, chan_b, chan_c,
             adc_trigger, converted,
      output ready
   );
endinterface

/* src/bcpwm_duty_conv.sv */
`timescale 1ns / 1ps

module bcpwm_duty_conv import bcpwm_pkg::*; (
   input  cfg_type            cfg,
   input  logic signed [15:0] duty,
   output conv_type           conv
);

   logic             neg;
   logic [15:0]      mag;
   logic [30:0]      prod;
   logic [TOP_W-1:0] d;
   logic [TOP_W-1:0] brake_diff;
   logic [TOP_W-1:0] brake_val;
   logic [17:0]      top_x4;
   logic [31:0]      recip_prod;
   logic [15:0]      q0;
   logic [18:0]      q0_x5;
   logic [18:0]      rem;
   logic [TOP_W-1:0] d_high;

   assign neg  = duty[15];
   assign mag  = neg ? (~duty + 16'd1) : duty;
   assign prod = {16'd0, mag[14:0]} * {15'd0, cfg.period_top};
   assign d    = (mag >= FULL_DUTY) ? cfg.period_top : prod[30:15];

   assign brake_diff = cfg.period_top - d;

   always_comb begin
      brake_val = {1'b0, brake_diff[TOP_W-1:1]};
      if (brake_val < cfg.brake_min) begin
         brake_val = cfg.brake_min;
      end
   end

   // floor(top * 4 / 5) by reciprocal, then one correction step
   assign top_x4     = {cfg.period_top, 2'b00};
   assign recip_prod = {14'd0, top_x4} * {18'd0, RECIP_5};
   assign q0         = recip_prod[31:16];
   assign q0_x5      = {3'd0, q0} * 19'd5;
   assign rem        = {1'b0, top_x4} - q0_x5;
   assign d_high     = (rem >= 19'd5) ? (q0 + 16'd1) : q0;

   assign conv.converted    = neg ? {1'b0, brake_val} : forward_value(cfg.period_top, d);
   assign conv.high_compare = forward_value(cfg.period_top, d_high);

endmodule

/* src/bldc_commutation_pwm_setup.sv */
`timescale 1ns / 1ps

// Six-step complementary PWM setup for a three-phase bridge. Each request transaction
// carries one command (commutation step, manipulate, energize, freewheel or convert
// only); each yields exactly one response transaction with the compare value and
// channel state of all three phases after the command, the ADC trigger point and the
// compare value converted from the request's duty. One request is accepted per clock
// cycle unless the response stalls; the request passes the input register, then the
// result register, around the single duty multiplier and the phase update logic. The
// response register lets a new request be taken while a result waits. The user must
// write registers through the csr port only while the block is idle, which it does
// not enforce; stored phase state changes only when a command uses the new values.

module bldc_commutation_pwm_setup import bcpwm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   bcpwm_req_if.sink              req_chan,
   bcpwm_rsp_if.source            rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type          cfg_ff;
   logic             s1_valid_ff;
   req_type          s1_data_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_ff;
   logic             accept_in;
   logic             adv;
   conv_type         conv;

   logic [CMP_W-1:0]  cmp_ff [NUM_PHASES];
   logic [CMP_W-1:0]  cmp_in [NUM_PHASES];
   logic [CHAN_W-1:0] chn_ff [NUM_PHASES];
   logic [CHAN_W-1:0] chn_in [NUM_PHASES];
   logic [TOP_W-1:0]  adc_ff;
   logic [TOP_W-1:0]  adc_in;

   logic [1:0]        cmd_v [NUM_PHASES];
   logic [1:0]        pol_v [NUM_PHASES];
   logic [TOP_W-1:0]  ht;
   logic [PHASE_W-1:0] pos_idx;
   logic [PHASE_W-1:0] neg_idx;
   logic [PHASE_W-1:0] flt_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period_top <= RESET_TOP;
         cfg_ff.brake_min  <= RESET_BRAKE_MIN;
         cfg_ff.adc_lead   <= RESET_ADC_ADV;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PERIOD_TOP: cfg_ff.period_top <= csr_wdata;
            CSR_BRAKE_MIN:  cfg_ff.brake_min  <= csr_wdata;
            CSR_ADC_ADV:    cfg_ff.adc_lead   <= csr_wdata[ADV_W-1:0];
            default: ;
         endcase
      end
   end

   assign adv            = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || adv;
   assign accept_in      = req_chan.valid && req_chan.ready;
   assign rsp_valid_in   = adv ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept_in) begin
            s1_valid_ff <= 1'b1;
         end else if (adv) begin
            s1_valid_ff <= 1'b0;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_in) begin
         s1_data_ff.mode           <= req_chan.mode;
         s1_data_ff.duty           <= req_chan.duty;
         s1_data_ff.positive_phase <= req_chan.positive_phase;
         s1_data_ff.negative_phase <= req_chan.negative_phase;
         s1_data_ff.floating_phase <= req_chan.floating_phase;
         s1_data_ff.cmd_a          <= req_chan.cmd_a;
         s1_data_ff.cmd_b          <= req_chan.cmd_b;
         s1_data_ff.cmd_c          <= req_chan.cmd_c;
         s1_data_ff.pol_a          <= req_chan.pol_a;
         s1_data_ff.pol_b          <= req_chan.pol_b;
         s1_data_ff.pol_c          <= req_chan.pol_c;
      end
   end

   bcpwm_duty_conv u_duty_conv (
      .cfg  (cfg_ff),
      .duty (s1_data_ff.duty),
      .conv (conv)
   );

   assign ht       = half_top(cfg_ff.period_top);
   assign pos_idx  = phase_sel(s1_data_ff.positive_phase);
   assign neg_idx  = phase_sel(s1_data_ff.negative_phase);
   assign flt_idx  = phase_sel(s1_data_ff.floating_phase);
   assign cmd_v[0] = s1_data_ff.cmd_a;
   assign cmd_v[1] = s1_data_ff.cmd_b;
   assign cmd_v[2] = s1_data_ff.cmd_c;
   assign pol_v[0] = s1_data_ff.pol_a;
   assign pol_v[1] = s1_data_ff.pol_b;
   assign pol_v[2] = s1_data_ff.pol_c;

   always_comb begin
      for (int i = 0; i < NUM_PHASES; i++) begin
         cmp_in[i] = cmp_ff[i];
         chn_in[i] = chn_ff[i];
      end
      adc_in = adc_ff;
      unique case (s1_data_ff.mode)
         MODE_STEP: begin
            chn_in[flt_idx] = CH_OFF;
            cmp_in[pos_idx] = conv.converted;
            chn_in[pos_idx] = CH_NONINV;
            cmp_in[neg_idx] = conv.converted;
            chn_in[neg_idx] = CH_INV;
            adc_in = adc_adjust(conv.converted, cfg_ff.adc_lead);
         end
         MODE_MANIP: begin
            for (int i = 0; i < NUM_PHASES; i++) begin
               unique case (cmd_v[i])
                  CMD_HIGH: begin
                     cmp_in[i] = conv.high_compare;
                     chn_in[i] = CH_NONINV;
                  end
                  CMD_HALF: begin
                     cmp_in[i] = {1'b0, ht};
                     chn_in[i] = CH_NONINV;
                  end
                  CMD_LOW: begin
                     cmp_in[i] = '0;
                     chn_in[i] = CH_NONINV;
                  end
                  CMD_FLOAT: begin
                     cmp_in[i] = {1'b0, ht};
                     chn_in[i] = CH_OFF;
                  end
               endcase
            end
            adc_in = adc_adjust({1'b0, ht}, cfg_ff.adc_lead);
         end
         MODE_ENERGIZE: begin
            for (int i = 0; i < NUM_PHASES; i++) begin
               unique case (pol_v[i])
                  POL_TOP: begin
                     cmp_in[i] = {1'b0, cfg_ff.period_top};
                     chn_in[i] = CH_NONINV;
                  end
                  POL_OFF: begin
                     cmp_in[i] = {1'b0, ht};
                     chn_in[i] = CH_OFF;
                  end
                  default: begin
                     cmp_in[i] = '0;
                     chn_in[i] = CH_NONINV;
                  end
               endcase
            end
            adc_in = adc_adjust({1'b0, cfg_ff.period_top}, cfg_ff.adc_lead);
         end
         MODE_FREEWHL: begin
            for (int i = 0; i < NUM_PHASES; i++) begin
               cmp_in[i] = {1'b0, ht};
               chn_in[i] = CH_OFF;
            end
            adc_in = adc_adjust({1'b0, ht}, cfg_ff.adc_lead);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PHASES; i++) begin
            cmp_ff[i] <= RESET_COMPARE;
            chn_ff[i] <= CH_OFF;
         end
         adc_ff <= RESET_ADC_POINT;
      end else if (adv) begin
         for (int i = 0; i < NUM_PHASES; i++) begin
            cmp_ff[i] <= cmp_in[i];
            chn_ff[i] <= chn_in[i];
         end
         adc_ff <= adc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff.compare_a   <= cmp_in[0];
         rsp_ff.compare_b   <= cmp_in[1];
         rsp_ff.compare_c   <= cmp_in[2];
         rsp_ff.chan_a      <= chn_in[0];
         rsp_ff.chan_b      <= chn_in[1];
         rsp_ff.chan_c      <= chn_in[2];
         rsp_ff.adc_trigger <= adc_in;
         rsp_ff.converted   <= conv.converted;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.compare_a   = rsp_ff.compare_a;
   assign rsp_chan.compare_b   = rsp_ff.compare_b;
   assign rsp_chan.compare_c   = rsp_ff.compare_c;
   assign rsp_chan.chan_a      = rsp_ff.chan_a;
   assign rsp_chan.chan_b      = rsp_ff.chan_b;
   assign rsp_chan.chan_c      = rsp_ff.chan_c;
   assign rsp_chan.adc_trigger = rsp_ff.adc_trigger;
   assign rsp_chan.converted   = rsp_ff.converted;

`ifndef SYNTHESIS
   a_hold_stage: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !adv) |=> s1_valid_ff)
      else $error("pending request dropped while response stalled");

   a_adv_valid: assert property (@(posedge clock) disable iff (reset)
      adv |=> rsp_valid_ff)
      else $error("advanced transaction produced no response");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request taken with both stages full and output stalled");

   a_adc_nonzero: assert property (@(posedge clock) disable iff (reset)
      adc_ff != '0)
      else $error("adc trigger point reached zero");
`endif

endmodule

/* bench/tb_bldc_commutation_pwm_setup.sv */
`timescale 1ns / 1ps

module tb_bldc_commutation_pwm_setup import bcpwm_pkg::*; ();

   class bridge_scoreboard;
      cfg_type           regs;
      logic [CMP_W-1:0]  compare [NUM_PHASES];
      logic [CHAN_W-1:0] channel [NUM_PHASES];
      logic [TOP_W-1:0]  trigger;
      rsp_type           expected_q[$];
      int                errors;

      function new();
         regs.period_top = RESET_TOP;
         regs.brake_min  = RESET_BRAKE_MIN;
         regs.adc_lead   = RESET_ADC_ADV;
         errors = 0;
         clear_phases();
         trigger = regs.period_top >> 2;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx,
                                 logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_PERIOD_TOP: regs.period_top = data;
            CSR_BRAKE_MIN:  regs.brake_min = data;
            CSR_ADC_ADV:    regs.adc_lead = data[ADV_W-1:0];
            default: ;
         endcase
      endfunction

      function int center_compare();
         int top;
         top = int'(regs.period_top);
         return (top + 1) / 2;
      endfunction

      function void clear_phases();
         for (int i = 0; i < NUM_PHASES; i++) begin
            compare[i] = CMP_W'(center_compare());
            channel[i] = CH_OFF;
         end
      endfunction

      function int above_center(int d);
         int top;
         top = int'(regs.period_top);
         return top - (top - d) / 2 + 1;
      endfunction

      function int duty_to_compare(logic [15:0] raw);
         longint mag;
         int     u, top, d, brake, full, outv;
         u = int'(raw);
         top = int'(regs.period_top);
         brake = int'(regs.brake_min);
         full = int'(FULL_DUTY);
         mag = longint'(raw[15] ? 65536 - u : u);
         if (mag >= full) begin
            d = top;
         end else begin
            d = int'((mag * top) >>> 15);
         end
         if (!raw[15]) begin
            return above_center(d);
         end
         outv = (top - d) / 2;
         if (outv < brake) begin
            outv = brake;
         end
         return outv;
      endfunction

      function void move_trigger(int v);
         int t, adv;
         adv = int'(regs.adc_lead);
         t = v / 2 - adv;
         if (t < 1) begin
            t = 1;
         end
         trigger = TOP_W'(t);
      endfunction

      function int phase_of(logic [1:0] raw);
         return (raw == 2'd3) ? 2 : int'(raw);
      endfunction

      function void load_phase(int p, int v, logic [CHAN_W-1:0] ch);
         compare[p] = CMP_W'(v);
         channel[p] = ch;
      endfunction

      function void take_command(req_type r);
         rsp_type    e;
         int         conv, top, half;
         logic [1:0] code [NUM_PHASES];
         top = int'(regs.period_top);
         half = center_compare();
         conv = duty_to_compare(r.duty);
         case (r.mode)
            MODE_STEP: begin
               channel[phase_of(r.floating_phase)] = CH_OFF;
               load_phase(phase_of(r.positive_phase), conv, CH_NONINV);
               load_phase(phase_of(r.negative_phase), conv, CH_INV);
               move_trigger(conv);
            end
            MODE_MANIP: begin
               code = '{r.cmd_a, r.cmd_b, r.cmd_c};
               clear_phases();
               for (int i = 0; i < NUM_PHASES; i++) begin
                  case (code[i])
                     CMD_HIGH: load_phase(i, above_center(top * 4 / 5), CH_NONINV);
                     CMD_HALF: load_phase(i, half, CH_NONINV);
                     CMD_LOW:  load_phase(i, 0, CH_NONINV);
                     default: ;
                  endcase
               end
               move_trigger(half);
            end
            MODE_ENERGIZE: begin
               code = '{r.pol_a, r.pol_b, r.pol_c};
               clear_phases();
               for (int i = 0; i < NUM_PHASES; i++) begin
                  if (code[i] == POL_TOP) begin
                     load_phase(i, top, CH_NONINV);
                  end else if (code[i] != POL_OFF) begin
                     load_phase(i, 0, CH_NONINV);
                  end
               end
               move_trigger(top);
            end
            MODE_FREEWHL: begin
               clear_phases();
               move_trigger(half);
            end
            default: ;
         endcase
         e.compare_a = compare[0];
         e.compare_b = compare[1];
         e.compare_c = compare[2];
         e.chan_a = channel[0];
         e.chan_b = channel[1];
         e.chan_c = channel[2];
         e.adc_trigger = trigger;
         e.converted = CMP_W'(conv);
         expected_q.push_back(e);
      endfunction

      function void check_field(string name, logic [CMP_W-1:0] want,
                                logic [CMP_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            $error("response transaction with no command outstanding");
            errors++;
            return;
         end
         want = expected_q.pop_front();
         check_field("compare_a", want.compare_a, got.compare_a);
         check_field("compare_b", want.compare_b, got.compare_b);
         check_field("compare_c", want.compare_c, got.compare_c);
         check_field("chan_a", CMP_W'(want.chan_a), CMP_W'(got.chan_a));
         check_field("chan_b", CMP_W'(want.chan_b), CMP_W'(got.chan_b));
         check_field("chan_c", CMP_W'(want.chan_c), CMP_W'(got.chan_c));
         check_field("adc_trigger", CMP_W'(want.adc_trigger), CMP_W'(got.adc_trigger));
         check_field("converted", want.converted, got.converted);
      endfunction
   endclass

   localparam int CLK_HALF        = 5;
   localparam int PIPE_LATENCY    = 2;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 84;

   localparam logic [MODE_W-1:0] MODE_CONVERT = 3'd4;
   localparam logic [MODE_W-1:0] MODE_RSVD_5  = 3'd5;
   localparam logic [MODE_W-1:0] MODE_RSVD_6  = 3'd6;
   localparam logic [MODE_W-1:0] MODE_RSVD_7  = 3'd7;

   localparam logic [1:0] POL_ZERO = 2'b11;
   localparam logic [1:0] POL_NEG2 = 2'b10;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   bit               calm;
   int               stall_left;
   int               cycle_count;
   rsp_type          observed;
   bridge_scoreboard sb;

   bcpwm_req_if req_if ();
   bcpwm_rsp_if rsp_if ();

   bldc_commutation_pwm_setup DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #CLK_HALF clock = ~clock;

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 60) begin
         return 0;
      end
      if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 20);
   endfunction

   always @(negedge clock) begin
      if (calm) begin
         stall_left = 0;
         rsp_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         stall_left = pick_gap();
         rsp_if.ready <= (stall_left == 0);
         if (stall_left > 0) begin
            stall_left--;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         observed.compare_a   = rsp_if.compare_a;
         observed.compare_b   = rsp_if.compare_b;
         observed.compare_c   = rsp_if.compare_c;
         observed.chan_a      = rsp_if.chan_a;
         observed.chan_b      = rsp_if.chan_b;
         observed.chan_c      = rsp_if.chan_c;
         observed.adc_trigger = rsp_if.adc_trigger;
         observed.converted   = rsp_if.converted;
         sb.check_response(observed);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic issue_command(input req_type r);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid          <= 1'b1;
      req_if.mode           <= r.mode;
      req_if.duty           <= r.duty;
      req_if.positive_phase <= r.positive_phase;
      req_if.negative_phase <= r.negative_phase;
      req_if.floating_phase <= r.floating_phase;
      req_if.cmd_a          <= r.cmd_a;
      req_if.cmd_b          <= r.cmd_b;
      req_if.cmd_c          <= r.cmd_c;
      req_if.pol_a          <= r.pol_a;
      req_if.pol_b          <= r.pol_b;
      req_if.pol_c          <= r.pol_c;
      do @(posedge clock); while (!req_if.ready);
      sb.take_command(r);
   endtask

   task automatic issue_fields(input logic [MODE_W-1:0] mode, input logic [15:0] duty,
                               input logic [1:0] pos, input logic [1:0] neg,
                               input logic [1:0] flt, input logic [1:0] ca,
                               input logic [1:0] cb, input logic [1:0] cc,
                               input logic [1:0] pa, input logic [1:0] pb,
                               input logic [1:0] pc);
      req_type r;
      r.mode = mode;
      r.duty = duty;
      r.positive_phase = pos;
      r.negative_phase = neg;
      r.floating_phase = flt;
      r.cmd_a = ca;
      r.cmd_b = cb;
      r.cmd_c = cc;
      r.pol_a = pa;
      r.pol_b = pb;
      r.pol_c = pc;
      issue_command(r);
   endtask

   function automatic logic [15:0] random_duty();
      if ($urandom_range(0, 3) != 0) begin
         return 16'($urandom);
      end
      case ($urandom_range(0, 10))
         0:       return 16'h0000;
         1:       return 16'h0001;
         2:       return 16'h7FFF;
         3:       return 16'h8000;
         4:       return 16'hFFFF;
         5:       return 16'd32736;
         6:       return 16'd32735;
         7:       return 16'h8020;
         8:       return 16'h8021;
         9:       return 16'h4000;
         default: return 16'hC000;
      endcase
   endfunction

   function automatic req_type random_command();
      req_type r;
      int      roll, p, n;
      r.duty = random_duty();
      r.positive_phase = 2'($urandom_range(0, 3));
      r.negative_phase = 2'($urandom_range(0, 3));
      r.floating_phase = 2'($urandom_range(0, 3));
      r.cmd_a = 2'($urandom_range(0, 3));
      r.cmd_b = 2'($urandom_range(0, 3));
      r.cmd_c = 2'($urandom_range(0, 3));
      r.pol_a = 2'($urandom_range(0, 3));
      r.pol_b = 2'($urandom_range(0, 3));
      r.pol_c = 2'($urandom_range(0, 3));
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
         r.mode = MODE_STEP;
         if ($urandom_range(0, 4) != 0) begin
            p = $urandom_range(0, 2);
            n = (p + $urandom_range(1, 2)) % 3;
            r.positive_phase = 2'(p);
            r.negative_phase = 2'(n);
            r.floating_phase = 2'(3 - p - n);
            if (r.floating_phase == 2'd2 && $urandom_range(0, 3) == 0) begin
               r.floating_phase = 2'd3;
            end
         end
      end else if (roll < 57) begin
         r.mode = MODE_MANIP;
      end else if (roll < 69) begin
         r.mode = MODE_ENERGIZE;
      end else if (roll < 77) begin
         r.mode = MODE_FREEWHL;
      end else if (roll < 92) begin
         r.mode = MODE_CONVERT;
      end else begin
         r.mode = MODE_W'($urandom_range(MODE_RSVD_5, MODE_RSVD_7));
      end
      return r;
   endfunction

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_register(idx, data);
   endtask

   task automatic drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      calm = 1'b0;
      stall_left = 0;
      cycle_count = 0;
      csr_we = 1'b0;
      csr_index = CSR_PERIOD_TOP;
      csr_wdata = '0;
      rsp_if.ready = 1'b0;
      req_if.valid = 1'b0;
      req_if.mode = MODE_STEP;
      req_if.duty = '0;
      req_if.positive_phase = '0;
      req_if.negative_phase = '0;
      req_if.floating_phase = '0;
      req_if.cmd_a = CMD_HIGH;
      req_if.cmd_b = CMD_HIGH;
      req_if.cmd_c = CMD_HIGH;
      req_if.pol_a = POL_OFF;
      req_if.pol_b = POL_OFF;
      req_if.pol_c = POL_OFF;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      issue_fields(MODE_CONVERT, 16'h0000, 0, 1, 2, CMD_HIGH, CMD_HIGH, CMD_HIGH,
                   POL_OFF, POL_OFF, POL_OFF);
      issue_fields(MODE_CONVERT, 16'h7FFF, 0, 1, 2, CMD_HIGH, CMD_HIGH, CMD_HIGH,
                   POL_OFF, POL_OFF, POL_OFF);
      issue_fields(MODE_CONVERT, 16'h8000, 0, 1, 2, CMD_HIGH, CMD_HIGH, CMD_HIGH,
                   POL_OFF, POL_OFF, POL_OFF);
      issue_fields(MODE_CONVERT, 16'd32736, 0, 1, 2, CMD_HIGH, CMD_HIGH, CMD_HIGH,
                   POL_OFF, POL_OFF, POL_OFF);
      issue_fields(MODE_CONVERT, 16'd32735, 0, 1, 2, CMD_HIGH, CMD_HIGH, CMD_HIGH,
                   POL_OFF, POL_OFF, POL_OFF);
      issue_fields(MODE_RSVD_5, 16'h8020, 3, 3, 3, CMD_FLOAT, CMD_FLOAT, CMD_FLOAT,
                   POL_ZERO, POL_ZERO, POL_ZERO);
      issue_fields(MODE_RSVD_6, 16'hFFFF, 1, 2, 0, CMD_LOW, CMD_HALF, CMD_HIGH,
                   POL_TOP, POL_NEG2, POL_ZERO);
      issue_fields(MODE_RSVD_7, 16'h0001, 2, 0, 1, CMD_HALF, CMD_LOW, CMD_FLOAT,
                   POL_NEG2, POL_TOP, POL_OFF);
      issue_fields(MODE_STEP, 16'h4000, 0, 1, 2, CMD_HIGH, CMD_HIGH, CMD_HIGH,
                   POL_OFF, POL_OFF, POL_OFF);
      issue_fields(MODE_STEP, 16'hC000, 1, 2, 0, CMD_HIGH, CMD_HIGH, CMD_HIGH,
                   POL_OFF, POL_OFF, POL_OFF);
      issue_fields(MODE_STEP, 16'h7FFF, 3, 0, 1, CMD_HIGH, CMD_HIGH, CMD_HIGH,
                   POL_OFF, POL_OFF, POL_OFF);
      issue_fields(MODE_STEP, 16'd1000, 2, 2, 2, CMD_HIGH, CMD_HIGH, CMD_HIGH,
                   POL_OFF, POL_OFF, POL_OFF);
      issue_fields(MODE_STEP, 16'h8000, 0, 0, 3, CMD_HIGH, CMD_HIGH, CMD_HIGH,
                   POL_OFF, POL_OFF, POL_OFF);
      issue_fields(MODE_STEP, 16'd20000, 1, 0, 1, CMD_HIGH, CMD_HIGH, CMD_HIGH,
                   POL_OFF, POL_OFF, POL_OFF);
      issue_fields(MODE_MANIP, 16'h1234, 0, 1, 2, CMD_HIGH, CMD_HALF, CMD_LOW,
                   POL_OFF, POL_OFF, POL_OFF);
      issue_fields(MODE_MANIP, 16'h8001, 0, 1, 2, CMD_FLOAT, CMD_FLOAT, CMD_HIGH,
                   POL_OFF, POL_OFF, POL_OFF);
      issue_fields(MODE_MANIP, 16'h0000, 0, 1, 2, CMD_LOW, CMD_FLOAT, CMD_HALF,
                   POL_OFF, POL_OFF, POL_OFF);
      issue_fields(MODE_ENERGIZE, 16'h0100, 0, 1, 2, CMD_HIGH, CMD_HIGH, CMD_HIGH,
                   POL_TOP, POL_ZERO, POL_OFF);
      issue_fields(MODE_ENERGIZE, 16'hFF00, 0, 1, 2, CMD_HIGH, CMD_HIGH, CMD_HIGH,
                   POL_NEG2, POL_TOP, POL_ZERO);
      issue_fields(MODE_ENERGIZE, 16'h0000, 0, 1, 2, CMD_HIGH, CMD_HIGH, CMD_HIGH,
                   POL_OFF, POL_OFF, POL_OFF);
      issue_fields(MODE_STEP, 16'hFF9C, 0, 1, 2, CMD_HIGH, CMD_HIGH, CMD_HIGH,
                   POL_OFF, POL_OFF, POL_OFF);
      issue_fields(MODE_FREEWHL, 16'h5555, 0, 1, 2, CMD_HIGH, CMD_HIGH, CMD_HIGH,
                   POL_OFF, POL_OFF, POL_OFF);
      issue_fields(MODE_STEP, 16'h7FFF, 2, 1, 0, CMD_HIGH, CMD_HIGH, CMD_HIGH,
                   POL_OFF, POL_OFF, POL_OFF);
      issue_fields(MODE_MANIP, 16'hAAAA, 0, 1, 2, CMD_HIGH, CMD_HIGH, CMD_HIGH,
                   POL_OFF, POL_OFF, POL_OFF);

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         drain();
         calm = (ph == 2 || ph == 5);
         case (ph)
            0: begin
               write_register(CSR_PERIOD_TOP, 16'd65535);
               write_register(CSR_BRAKE_MIN, 16'd32768);
               write_register(CSR_ADC_ADV, 16'd0);
            end
            1: begin
               write_register(CSR_PERIOD_TOP, 16'd1);
               write_register(CSR_BRAKE_MIN, 16'd0);
               write_register(CSR_ADC_ADV, 16'd26214);
            end
            2: begin
               write_register(CSR_PERIOD_TOP, 16'd2399);
               write_register(CSR_BRAKE_MIN, 16'd150);
               write_register(CSR_ADC_ADV, 16'd300);
            end
            4: begin
               write_register(CSR_PERIOD_TOP, 16'd65535);
               write_register(CSR_BRAKE_MIN, 16'd0);
               write_register(CSR_ADC_ADV, 16'd26214);
            end
            default: begin
               write_register(CSR_PERIOD_TOP, 16'($urandom_range(1, 65535)));
               write_register(CSR_BRAKE_MIN, 16'($urandom_range(0, 32768)));
               write_register(CSR_ADC_ADV, 16'($urandom_range(0, 26214)));
               write_register(CSR_UNUSED, 16'($urandom));
            end
         endcase
         repeat (ITEMS_PER_PHASE) issue_command(random_command());
      end

      drain();
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
